// File: hdl/vdu_pkg.sv
// Package for the vector distance unit: widths, codes, the job record passed
// from the accumulating front end to the square-root back end, back-end states.
// No dependencies.
`timescale 1ns / 1ps

package vdu_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int MAX_DIM_DEF    = 64;

  // Widest coordinate the job record can carry.
  localparam int LDIFF_W = 24;

  localparam int SUM_W  = 39;
  localparam int FRAC_W = 8;
  localparam int DIST_W = 28;

  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Square root of sum * 2^(2*FRAC_W), one result bit per step.
  localparam int ROOT_STEPS = (SUM_W + 2 * FRAC_W + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_STEPS;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  // Job queue depth, a power of two.
  localparam int QUEUE_DEPTH = 2;

  localparam logic MODE_EUCLID = 1'b0;
  localparam logic MODE_LINF   = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [SUM_W-1:0]   sum;
    logic [LDIFF_W-1:0] ldiff;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROOT,
    BK_HOLD
  } back_state_t;

endpackage

// File: hdl/vdu_channels.sv
// Handshake channels of the vector distance unit: coordinate pairs in,
// distances out, and the mode register write channel. Depends on vdu_pkg.
`timescale 1ns / 1ps

interface vdu_in_if #(
  parameter int COORD_BITS = vdu_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         last_element;

  modport source (output valid, x_coord, y_coord, last_element, input ready);
  modport sink   (input valid, x_coord, y_coord, last_element, output ready);
endinterface

interface vdu_out_if;
  logic                        valid;
  logic                        ready;
  logic [vdu_pkg::DIST_W-1:0]  distance;

  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

interface vdu_cfg_if;
  logic valid;
  logic ready;
  logic metric_mode;

  modport source (output valid, metric_mode, input ready);
  modport sink   (input valid, metric_mode, output ready);
endinterface

// File: hdl/vdu_front.sv
// Front end: takes coordinate pairs, forms |x - y| and its square in two
// stages, accumulates per vector and emits one job per vector. Depends on vdu_pkg.
`timescale 1ns / 1ps

module vdu_front #(
  parameter int COORD_BITS = vdu_pkg::COORD_BITS_DEF,
  parameter int MAX_DIM    = vdu_pkg::MAX_DIM_DEF
) (
  input  logic          clk,
  input  logic          rst,
  vdu_in_if.sink        pairs,
  input  logic          metric_mode,
  output vdu_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_ready
);
  import vdu_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int ADD_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

  logic                         stall;
  logic                         take;
  logic                         keep;
  logic [CNT_W-1:0]             count;
  logic signed [COORD_BITS:0]   diff;
  logic [COORD_BITS-1:0]        ad;

  logic                         s1_valid;
  logic                         s1_last;
  logic                         s1_mode;
  logic [COORD_BITS-1:0]        s1_ad;

  logic                         s2_valid;
  logic                         s2_last;
  logic                         s2_mode;
  logic [COORD_BITS-1:0]        s2_ad;
  logic [SQ_W-1:0]              s2_sq;

  logic [SUM_W-1:0]             sum;
  logic [SUM_W-1:0]             sum_next;
  logic [COORD_BITS-1:0]        ldiff;
  logic [COORD_BITS-1:0]        ldiff_next;
  logic [ADD_W-1:0]             add;

  // The whole pipe freezes while a finished vector waits for queue space.
  assign stall       = s2_valid && s2_last && !job_ready;
  assign pairs.ready = !stall;
  assign take        = pairs.valid && !stall;

  // Pairs beyond MAX_DIM contribute nothing but can still close the vector.
  assign keep = (count < CNT_W'(MAX_DIM));
  assign diff = (COORD_BITS + 1)'(pairs.x_coord) - (COORD_BITS + 1)'(pairs.y_coord);
  assign ad   = diff[COORD_BITS] ? COORD_BITS'(-diff) : COORD_BITS'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take) begin
      if (pairs.last_element) begin
        count <= '0;
      end else if (keep) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_ad   <= keep ? ad : '0;
      s1_last <= pairs.last_element;
      s1_mode <= metric_mode;
      s2_ad   <= s1_ad;
      s2_sq   <= SQ_W'(s1_ad) * SQ_W'(s1_ad);
      s2_last <= s1_last;
      s2_mode <= s1_mode;
    end
  end

  assign add        = ADD_W'(sum) + ADD_W'(s2_sq);
  assign sum_next   = (add > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(add);
  assign ldiff_next = (s2_ad > ldiff) ? s2_ad : ldiff;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      ldiff <= '0;
    end else if (s2_valid && !stall) begin
      if (s2_last) begin
        sum   <= '0;
        ldiff <= '0;
      end else begin
        sum   <= sum_next;
        ldiff <= ldiff_next;
      end
    end
  end

  assign job_valid = s2_valid && s2_last;
  assign job.mode  = s2_mode;
  assign job.sum   = sum_next;
  assign job.ldiff = LDIFF_W'(ldiff_next);

endmodule

// File: hdl/vdu_queue.sv
// Short job queue between the front end and the back end.
// Depends on vdu_pkg (job_t, QUEUE_DEPTH).
`timescale 1ns / 1ps

module vdu_queue (
  input  logic          clk,
  input  logic          rst,
  input  vdu_pkg::job_t push_job,
  input  logic          push_valid,
  output logic          push_ready,
  output vdu_pkg::job_t pop_job,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import vdu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  job_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != FILL_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

// File: hdl/vdu_back.sv
// Back end: turns a job into a distance. Bit-serial square root for Euclidean
// jobs, shift and clamp for L-infinity, then an output register. Depends on vdu_pkg.
`timescale 1ns / 1ps

module vdu_back (
  input  logic          clk,
  input  logic          rst,
  input  vdu_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  vdu_out_if.source     result
);
  import vdu_pkg::*;

  localparam int LIN_W = LDIFF_W + FRAC_W;

  back_state_t             state;
  back_state_t             state_next;
  logic                    take;
  logic [RAD_W-1:0]        rad;
  logic [ROOT_STEPS:0]     rem;
  logic [ROOT_STEPS-1:0]   root;
  logic [STEP_W-1:0]       step;
  logic [DIST_W-1:0]       held_dist;
  logic [LIN_W-1:0]        lin_ext;
  logic [DIST_W-1:0]       lin_dist;
  logic [ROOT_STEPS+2:0]   rem_t;
  logic [ROOT_STEPS+2:0]   trial;
  logic                    ge;
  logic [ROOT_STEPS:0]     rem_new;
  logic [ROOT_STEPS-1:0]   root_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    job_ready    = 1'b0;
    result.valid = 1'b0;
    unique case (state)
      BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = (job.mode == MODE_LINF) ? BK_HOLD : BK_ROOT;
        end
      end
      BK_ROOT: begin
        if (step == '0) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        result.valid = 1'b1;
        if (result.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign take = job_valid && job_ready;

  assign lin_ext  = LIN_W'(job.ldiff) << FRAC_W;
  assign lin_dist = (lin_ext > LIN_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(lin_ext);

  // One root bit per step: bring down two radicand bits, try 4*root + 1.
  assign rem_t    = {rem, rad[RAD_W-1 -: 2]};
  assign trial    = {1'b0, root, 2'b01};
  assign ge       = (rem_t >= trial);
  assign rem_new  = ge ? (ROOT_STEPS + 1)'(rem_t - trial) : (ROOT_STEPS + 1)'(rem_t);
  assign root_new = {root[ROOT_STEPS-2:0], ge};

  always_ff @(posedge clk) begin
    if (take) begin
      if (job.mode == MODE_LINF) begin
        held_dist <= lin_dist;
      end else begin
        rad  <= RAD_W'({job.sum, {(2 * FRAC_W){1'b0}}});
        rem  <= '0;
        root <= '0;
        step <= STEP_W'(ROOT_STEPS - 1);
      end
    end else if (state == BK_ROOT) begin
      rad  <= rad << 2;
      rem  <= rem_new;
      root <= root_new;
      step <= step - STEP_W'(1);
      if (step == '0) begin
        held_dist <= DIST_W'(root_new);
      end
    end
  end

  assign result.distance = held_dist;

endmodule

// File: hdl/vector_distance_unit_core.sv
// Vector distance unit, top level. After a vector's last pair, its job passes
// the front end stages and the queue; L-infinity jobs skip the bit-serial root.
// One coordinate pair is taken per cycle unless the front end stalls on a full
// queue; the back end takes a new job only once its last distance is taken.
// Reset (rst, synchronous) empties the pipe and queue, clears the running sums
// and sets metric_mode to Euclidean. Depends on vdu_pkg, vdu_channels, submodules.
`timescale 1ns / 1ps

module vector_distance_unit_core #(
  parameter int COORD_BITS = vdu_pkg::COORD_BITS_DEF,
  parameter int MAX_DIM    = vdu_pkg::MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst,
  vdu_cfg_if.sink    cfg,
  vdu_in_if.sink     pairs,
  vdu_out_if.source  result
);
  import vdu_pkg::*;

  // Mode register. The mode rides along with each pair so that the mode
  // present at a vector's last pair picks its metric.
  logic metric_mode;

  // Front end to queue.
  job_t job;
  logic job_valid;
  logic job_ready;

  // Queue to back end.
  job_t q_job;
  logic q_job_valid;
  logic q_job_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_EUCLID;
    end else if (cfg.valid) begin
      metric_mode <= cfg.metric_mode;
    end
  end

  // Front end: per-pair difference, square and running sum / maximum.
  // Saturates the sum at 39 bits, drops pairs past MAX_DIM.
  vdu_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_DIM    (MAX_DIM)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pairs       (pairs),
    .metric_mode (metric_mode),
    .job         (job),
    .job_valid   (job_valid),
    .job_ready   (job_ready)
  );

  // Two-entry queue: the front end keeps streaming the next vector while the
  // back end grinds through a square root.
  vdu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (job),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .pop_job    (q_job),
    .pop_valid  (q_job_valid),
    .pop_ready  (q_job_ready)
  );

  // Back end: root or clamp, then holds the distance until taken.
  vdu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .job_valid (q_job_valid),
    .job_ready (q_job_ready),
    .result    (result)
  );

  // A finished vector blocked by a full queue must stop pair intake.
  a_block_intake: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_ready) |-> !pairs.ready)
    else $error("pair intake open while a finished vector is blocked");

  // L-infinity jobs present their distance in the cycle after they leave the queue.
  a_linf_fast: assert property (@(posedge clk) disable iff (rst)
    (q_job_valid && q_job_ready && q_job.mode == MODE_LINF) |=> result.valid)
    else $error("L-infinity distance not presented after job pop");

  // Euclidean jobs go through the root unit, never straight to the output.
  a_euclid_root: assert property (@(posedge clk) disable iff (rst)
    (q_job_valid && q_job_ready && q_job.mode == MODE_EUCLID) |=> !result.valid)
    else $error("Euclidean distance presented without root iterations");

  // The back end takes no new job while a distance is still held.
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !q_job_ready)
    else $error("back end took a job while holding a distance");

endmodule
